FILE: hw/rtl/kts_pkg.sv
package kts_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned MaxEdges    = 256;
  localparam int unsigned VtxW        = 5;
  localparam int unsigned CntW        = 6;
  localparam int unsigned EdgeW       = 8;
  localparam int unsigned LinkW       = 9;
  localparam int unsigned DegW        = 9;

  localparam logic [LinkW-1:0] NullLink = 9'd256;

  typedef enum logic [1:0] {
    OpAddEdge = 2'd0,
    OpSort    = 2'd1,
    OpClear   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StAddWr,
    StClrHead,
    StZeroDeg,
    StCntHead,
    StHeadLoad,
    StEdgeRd,
    StEdgeDeg,
    StEdgeUpd,
    StSeed,
    StSeedChk,
    StPop,
    StPopOut,
    StEnd
  } state_e;

endpackage

FILE: hw/rtl/kahn_topological_sort.sv
// Each beat with start high and busy low is one command. A dropped add edge or
// the unused code keeps busy low; a stored add edge holds busy while it writes
// the edge, and a clear holds it while it sweeps the list heads. A sort with a
// vertex count of zero goes straight to the end marker; otherwise it zeroes the
// degrees, walks each vertex's edge list to count the in-degrees, seeds the
// queue with the vertices of degree zero, then pops and emits each queued
// vertex while it walks that vertex's edges, and finishes with the end marker.
// Results come with strobe_o high for one cycle each and the receiver cannot
// stall them; the end marker comes in the last busy cycle. After reset busy
// stays high while the list heads are cleared.
module kahn_topological_sort (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic [1:0] operation_i,
  input  logic [4:0] src_vertex_i,
  input  logic [4:0] dst_vertex_i,
  output logic       strobe_o,
  output logic       kind_o,
  output logic [4:0] vertex_o,
  output logic       has_cycle_o,
  output logic       edges_dropped_o,
  output logic       last_o
);

  kts_pkg::state_e state_q, state_d;

  logic [kts_pkg::LinkW-1:0] head_mem [kts_pkg::MaxVertices];
  logic [kts_pkg::VtxW-1:0]  tgt_mem  [kts_pkg::MaxEdges];
  logic [kts_pkg::LinkW-1:0] link_mem [kts_pkg::MaxEdges];
  logic [kts_pkg::DegW-1:0]  deg_mem  [kts_pkg::MaxVertices];
  logic [kts_pkg::VtxW-1:0]  que_mem  [kts_pkg::MaxVertices];

  logic [kts_pkg::CntW-1:0]  vcount_q;
  logic [kts_pkg::LinkW-1:0] etotal_q, etotal_d;
  logic                      drop_q, drop_d;
  logic [kts_pkg::CntW-1:0]  idx_q, idx_d;
  logic [kts_pkg::LinkW-1:0] eptr_q, eptr_d;
  logic [kts_pkg::CntW-1:0]  rpos_q, rpos_d, wpos_q, wpos_d;
  logic [kts_pkg::CntW-1:0]  emit_q, emit_d;
  logic                      mode_q, mode_d;
  logic [kts_pkg::VtxW-1:0]  src_q, dst_q;

  logic [kts_pkg::LinkW-1:0] head_rd_q;
  logic [kts_pkg::VtxW-1:0]  tgt_rd_q;
  logic [kts_pkg::LinkW-1:0] link_rd_q;
  logic [kts_pkg::DegW-1:0]  deg_rd_q;
  logic [kts_pkg::VtxW-1:0]  que_rd_q;

  logic                      head_we;
  logic [kts_pkg::VtxW-1:0]  head_wa, head_ra;
  logic [kts_pkg::LinkW-1:0] head_wd;
  logic                      edge_we;
  logic [kts_pkg::EdgeW-1:0] edge_a;
  logic                      deg_we;
  logic [kts_pkg::VtxW-1:0]  deg_wa, deg_ra;
  logic [kts_pkg::DegW-1:0]  deg_wd;
  logic                      que_we;
  logic [kts_pkg::VtxW-1:0]  que_wa, que_ra;
  logic [kts_pkg::VtxW-1:0]  que_wd;

  logic [kts_pkg::CntW-1:0] n_eff;
  logic [kts_pkg::CntW-1:0] n_last;
  logic                     accept;
  logic                     bad_edge;
  logic                     tgt_in;
  logic                     list_end;

  assign n_eff  = (vcount_q > kts_pkg::CntW'(kts_pkg::MaxVertices))
                ? kts_pkg::CntW'(kts_pkg::MaxVertices) : vcount_q;
  assign n_last = n_eff - kts_pkg::CntW'(1);
  assign busy   = (state_q != kts_pkg::StIdle);
  assign accept = start && !busy;
  assign bad_edge = ({1'b0, src_vertex_i} >= n_eff) || ({1'b0, dst_vertex_i} >= n_eff) ||
                    (etotal_q >= kts_pkg::LinkW'(kts_pkg::MaxEdges));
  assign tgt_in   = ({1'b0, tgt_rd_q} < n_eff);
  assign list_end = (eptr_q == kts_pkg::NullLink);

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
    if (edge_we) begin
      tgt_mem[edge_a]  <= dst_q;
      link_mem[edge_a] <= head_rd_q;
    end
    tgt_rd_q  <= tgt_mem[edge_a];
    link_rd_q <= link_mem[edge_a];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd_q <= deg_mem[deg_ra];
    if (que_we) que_mem[que_wa] <= que_wd;
    que_rd_q <= que_mem[que_ra];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kts_pkg::StIdle: begin
        if (accept) begin
          unique case (kts_pkg::op_e'(operation_i))
            kts_pkg::OpAddEdge: state_d = bad_edge ? kts_pkg::StIdle : kts_pkg::StAddWr;
            kts_pkg::OpSort:    state_d = (n_eff == '0) ? kts_pkg::StEnd
                                                        : kts_pkg::StZeroDeg;
            kts_pkg::OpClear:   state_d = kts_pkg::StClrHead;
            kts_pkg::OpNone:    state_d = kts_pkg::StIdle;
          endcase
        end
      end
      kts_pkg::StAddWr: state_d = kts_pkg::StIdle;
      kts_pkg::StClrHead:
        if (idx_q == kts_pkg::CntW'(kts_pkg::MaxVertices - 1)) state_d = kts_pkg::StIdle;
      kts_pkg::StZeroDeg:
        if (idx_q == n_last) state_d = kts_pkg::StCntHead;
      kts_pkg::StCntHead: state_d = kts_pkg::StHeadLoad;
      kts_pkg::StHeadLoad: state_d = kts_pkg::StEdgeRd;
      kts_pkg::StEdgeRd: begin
        if (!list_end) state_d = kts_pkg::StEdgeDeg;
        else if (mode_q) state_d = kts_pkg::StPop;
        else state_d = (idx_q == n_last) ? kts_pkg::StSeed : kts_pkg::StCntHead;
      end
      kts_pkg::StEdgeDeg: state_d = kts_pkg::StEdgeUpd;
      kts_pkg::StEdgeUpd: state_d = kts_pkg::StEdgeRd;
      kts_pkg::StSeed: state_d = kts_pkg::StSeedChk;
      kts_pkg::StSeedChk: state_d = (idx_q == n_last) ? kts_pkg::StPop : kts_pkg::StSeed;
      kts_pkg::StPop: state_d = (rpos_q < wpos_q) ? kts_pkg::StPopOut : kts_pkg::StEnd;
      kts_pkg::StPopOut: state_d = kts_pkg::StHeadLoad;
      kts_pkg::StEnd: state_d = kts_pkg::StIdle;
      default: state_d = kts_pkg::StIdle;
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    eptr_d   = eptr_q;
    rpos_d   = rpos_q;
    wpos_d   = wpos_q;
    emit_d   = emit_q;
    mode_d   = mode_q;
    etotal_d = etotal_q;
    drop_d   = drop_q;
    head_we  = 1'b0;
    head_wa  = idx_q[kts_pkg::VtxW-1:0];
    head_wd  = kts_pkg::NullLink;
    head_ra  = idx_q[kts_pkg::VtxW-1:0];
    edge_we  = 1'b0;
    edge_a   = eptr_q[kts_pkg::EdgeW-1:0];
    deg_we   = 1'b0;
    deg_wa   = tgt_rd_q;
    deg_wd   = '0;
    deg_ra   = tgt_rd_q;
    que_we   = 1'b0;
    que_wa   = wpos_q[kts_pkg::VtxW-1:0];
    que_wd   = tgt_rd_q;
    que_ra   = rpos_q[kts_pkg::VtxW-1:0];
    strobe_o        = 1'b0;
    kind_o          = 1'b0;
    vertex_o        = '0;
    has_cycle_o     = 1'b0;
    edges_dropped_o = 1'b0;
    last_o          = 1'b0;
    unique case (state_q)
      kts_pkg::StIdle: begin
        idx_d   = '0;
        head_ra = src_vertex_i;
        if (accept) begin
          unique case (kts_pkg::op_e'(operation_i))
            kts_pkg::OpAddEdge: if (bad_edge) drop_d = 1'b1;
            kts_pkg::OpSort: begin
              rpos_d = '0;
              wpos_d = '0;
              emit_d = '0;
              mode_d = 1'b0;
            end
            kts_pkg::OpClear: begin
              etotal_d = '0;
              drop_d   = 1'b0;
            end
            kts_pkg::OpNone: ;
          endcase
        end
      end
      kts_pkg::StAddWr: begin
        edge_we  = 1'b1;
        edge_a   = etotal_q[kts_pkg::EdgeW-1:0];
        head_we  = 1'b1;
        head_wa  = src_q;
        head_wd  = etotal_q;
        etotal_d = etotal_q + kts_pkg::LinkW'(1);
      end
      kts_pkg::StClrHead: begin
        head_we = 1'b1;
        idx_d   = idx_q + kts_pkg::CntW'(1);
      end
      kts_pkg::StZeroDeg: begin
        deg_we = 1'b1;
        deg_wa = idx_q[kts_pkg::VtxW-1:0];
        idx_d  = (idx_q == n_last) ? '0 : idx_q + kts_pkg::CntW'(1);
      end
      kts_pkg::StCntHead: ;
      kts_pkg::StHeadLoad: eptr_d = head_rd_q;
      kts_pkg::StEdgeRd: begin
        if (list_end && !mode_q) begin
          idx_d = (idx_q == n_last) ? '0 : idx_q + kts_pkg::CntW'(1);
        end
      end
      kts_pkg::StEdgeDeg: ;
      kts_pkg::StEdgeUpd: begin
        eptr_d = link_rd_q;
        if (tgt_in) begin
          if (!mode_q) begin
            deg_we = 1'b1;
            deg_wd = deg_rd_q + kts_pkg::DegW'(1);
          end else if (deg_rd_q != '0) begin
            deg_we = 1'b1;
            deg_wd = deg_rd_q - kts_pkg::DegW'(1);
            if (deg_rd_q == kts_pkg::DegW'(1) &&
                wpos_q < kts_pkg::CntW'(kts_pkg::MaxVertices)) begin
              que_we = 1'b1;
              wpos_d = wpos_q + kts_pkg::CntW'(1);
            end
          end
        end
      end
      kts_pkg::StSeed: deg_ra = idx_q[kts_pkg::VtxW-1:0];
      kts_pkg::StSeedChk: begin
        if (deg_rd_q == '0) begin
          que_we = 1'b1;
          que_wd = idx_q[kts_pkg::VtxW-1:0];
          wpos_d = wpos_q + kts_pkg::CntW'(1);
        end
        if (idx_q == n_last) mode_d = 1'b1;
        else idx_d = idx_q + kts_pkg::CntW'(1);
      end
      kts_pkg::StPop: ;
      kts_pkg::StPopOut: begin
        strobe_o = 1'b1;
        vertex_o = que_rd_q;
        head_ra  = que_rd_q;
        rpos_d   = rpos_q + kts_pkg::CntW'(1);
        emit_d   = emit_q + kts_pkg::CntW'(1);
      end
      kts_pkg::StEnd: begin
        strobe_o        = 1'b1;
        kind_o          = 1'b1;
        has_cycle_o     = (emit_q != n_eff);
        edges_dropped_o = drop_q;
        last_o          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kts_pkg::StClrHead;
      vcount_q <= kts_pkg::CntW'(kts_pkg::MaxVertices);
      etotal_q <= '0;
      drop_q   <= 1'b0;
      idx_q    <= '0;
      eptr_q   <= '0;
      rpos_q   <= '0;
      wpos_q   <= '0;
      emit_q   <= '0;
      mode_q   <= 1'b0;
      src_q    <= '0;
      dst_q    <= '0;
    end else begin
      state_q  <= state_d;
      etotal_q <= etotal_d;
      drop_q   <= drop_d;
      idx_q    <= idx_d;
      eptr_q   <= eptr_d;
      rpos_q   <= rpos_d;
      wpos_q   <= wpos_d;
      emit_q   <= emit_d;
      mode_q   <= mode_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (accept) begin
        src_q <= src_vertex_i;
        dst_q <= dst_vertex_i;
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  class topo_scoreboard;
    logic [5:0] count_reg;
    logic [4:0] edge_dst[$];
    int unsigned edge_src[$];
    bit drop_flag;
    logic [8:0] order_q[$];
    int unsigned errors;
    int unsigned sorts;
    int unsigned results;

    function new();
      count_reg = 6'd32;
      drop_flag = 1'b0;
      errors = 0;
      sorts = 0;
      results = 0;
    endfunction

    function void note_config(logic [5:0] v);
      count_reg = v;
    endfunction

    function void note_command(kts_pkg::op_e op, logic [4:0] src, logic [4:0] dst);
      int unsigned n;
      int unsigned deg[kts_pkg::MaxVertices];
      int unsigned rq[$];
      int unsigned node;
      int unsigned emitted;
      n = (count_reg > kts_pkg::MaxVertices) ? kts_pkg::MaxVertices : count_reg;
      case (op)
        kts_pkg::OpAddEdge: begin
          if (src >= n || dst >= n || edge_dst.size() >= kts_pkg::MaxEdges) begin
            drop_flag = 1'b1;
          end else begin
            edge_src.push_back(src);
            edge_dst.push_back(dst);
          end
        end
        kts_pkg::OpClear: begin
          edge_src.delete();
          edge_dst.delete();
          drop_flag = 1'b0;
        end
        kts_pkg::OpSort: begin
          sorts++;
          emitted = 0;
          for (int i = 0; i < kts_pkg::MaxVertices; i++) deg[i] = 0;
          for (int e = 0; e < edge_dst.size(); e++) begin
            if (edge_src[e] < n && edge_dst[e] < n) deg[edge_dst[e]]++;
          end
          for (int i = 0; i < n; i++) if (deg[i] == 0) rq.push_back(i);
          while (rq.size() > 0) begin
            node = rq.pop_front();
            order_q.push_back({1'b0, node[4:0], 3'b000});
            emitted++;
            // Lists run newest first, so walk the edges in reverse order.
            for (int e = edge_dst.size() - 1; e >= 0; e--) begin
              if (edge_src[e] == node && edge_dst[e] < n && deg[edge_dst[e]] > 0) begin
                deg[edge_dst[e]]--;
                if (deg[edge_dst[e]] == 0) rq.push_back(edge_dst[e]);
              end
            end
          end
          order_q.push_back({1'b1, 5'd0, emitted != n, drop_flag, 1'b1});
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic k, logic [4:0] v, logic c, logic d, logic l);
      logic [8:0] exp_r;
      results++;
      if (order_q.size() == 0) begin
        $error("unexpected result kind=%0d vertex=%0d", k, v);
        errors++;
        return;
      end
      exp_r = order_q.pop_front();
      if (k !== exp_r[8]) begin
        $error("kind expected %0d actual %0d", exp_r[8], k); errors++;
      end
      if (v !== exp_r[7:3]) begin
        $error("vertex expected %0d actual %0d", exp_r[7:3], v); errors++;
      end
      if (c !== exp_r[2]) begin
        $error("has_cycle expected %0d actual %0d", exp_r[2], c); errors++;
      end
      if (d !== exp_r[1]) begin
        $error("edges_dropped expected %0d actual %0d", exp_r[1], d); errors++;
      end
      if (l !== exp_r[0]) begin
        $error("last expected %0d actual %0d", exp_r[0], l); errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;
  logic [1:0] operation_i;
  logic [4:0] src_vertex_i;
  logic [4:0] dst_vertex_i;
  logic       strobe_o;
  logic       kind_o;
  logic [4:0] vertex_o;
  logic       has_cycle_o;
  logic       edges_dropped_o;
  logic       last_o;

  topo_scoreboard sb;

  kahn_topological_sort dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i, .operation_i,
    .src_vertex_i, .dst_vertex_i, .strobe_o, .kind_o, .vertex_o, .has_cycle_o,
    .edges_dropped_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_result(kind_o, vertex_o, has_cycle_o, edges_dropped_o, last_o);
    end
  end

  // Start stays high across a beat when the next command follows with no gap.
  task automatic send_command(kts_pkg::op_e op, logic [4:0] src, logic [4:0] dst);
    int unsigned gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    src_vertex_i <= src;
    dst_vertex_i <= dst;
    do @(posedge clk_i); while (busy);
    sb.note_command(op, src, dst);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || sb.order_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [5:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.note_config(v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_edge(logic [4:0] s, logic [4:0] d);
    send_command(kts_pkg::OpAddEdge, s, d);
  endtask

  task automatic random_graph(int unsigned edges, bit acyclic, int unsigned n);
    logic [4:0] a, b;
    for (int i = 0; i < edges; i++) begin
      a = 5'($urandom_range(0, n - 1));
      b = 5'($urandom_range(0, n - 1));
      if (acyclic && a > b) add_edge(b, a);
      else if (acyclic && a == b) add_edge(a, 5'((a + 1) % n));
      else add_edge(a, b);
    end
  endtask

  int unsigned sent;
  int unsigned n;
  int unsigned edges;

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    operation_i = kts_pkg::OpNone;
    src_vertex_i = '0;
    dst_vertex_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    sent = 0;

    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    add_edge(5'd0, 5'd31);
    add_edge(5'd31, 5'd5);
    add_edge(5'd0, 5'd5);
    add_edge(5'd5, 5'd3);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    add_edge(5'd3, 5'd0);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    send_command(kts_pkg::OpNone, 5'd31, 5'd31);
    send_command(kts_pkg::OpClear, 5'd0, 5'd0);
    write_count(6'd4);
    add_edge(5'd4, 5'd1);
    add_edge(5'd1, 5'd31);
    add_edge(5'd2, 5'd1);
    add_edge(5'd3, 5'd2);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    write_count(6'd2);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    write_count(6'd0);
    add_edge(5'd0, 5'd0);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    write_count(6'd63);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    write_count(6'd1);
    send_command(kts_pkg::OpClear, 5'd0, 5'd0);
    add_edge(5'd0, 5'd0);
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    sent = 22;

    // Overfill the edge store once to reach the capacity drop.
    write_count(6'd32);
    send_command(kts_pkg::OpClear, 5'd0, 5'd0);
    for (int i = 0; i < 260; i++) begin
      add_edge(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    end
    send_command(kts_pkg::OpSort, 5'd0, 5'd0);
    sent += 262;

    while (sent < 450) begin
      case ($urandom_range(0, 5))
        0: write_count(6'd32);
        1: write_count(6'd1);
        2: write_count(6'($urandom_range(0, 63)));
        default: write_count(6'($urandom_range(2, 10)));
      endcase
      n = (sb.count_reg == 0) ? 1 : ((sb.count_reg > 32) ? 32 : sb.count_reg);
      send_command(kts_pkg::OpClear, 5'd0, 5'd0);
      edges = $urandom_range(0, 12);
      random_graph(edges, $urandom_range(0, 2) != 0, n);
      if ($urandom_range(0, 3) == 0) begin
        send_command(kts_pkg::op_e'(2'($urandom_range(0, 3))), 5'($urandom), 5'($urandom));
        sent++;
      end
      send_command(kts_pkg::OpSort, 5'd0, 5'd0);
      if ($urandom_range(0, 2) == 0) begin
        write_count(6'($urandom_range(0, 63)));
        send_command(kts_pkg::OpSort, 5'd0, 5'd0);
        sent++;
      end
      sent += edges + 2;
    end

    wait_idle();
    $display("Ran %0d sorts giving %0d results over graphs of 0 to 32 vertices,",
             sb.sorts, sb.results);
    $display("with cycles, dropped edges and a full edge store among them.");
    if (sb.errors == 0 && sb.order_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: kahn_topological_sort.f
hw/rtl/kts_pkg.sv
hw/rtl/kahn_topological_sort.sv
tb/sv/testbench.sv
